@@ design/pabf_pkg.sv @@
// Shared types for the packet aligned byte FIFO: request and result
// payloads, operation and status codes, and the controller state type.
// No dependencies.
package pabf_pkg;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_FULL    = 2'd1,
		STS_EMPTY   = 2'd2,
		STS_INVALID = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_READ = 2'd1,
		ST_SKIP = 2'd2
	} state_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic [9:0] msg_len;
		logic       start_req;
		logic [6:0] req_size;
	} cmd_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] rdata;
		logic       rdata_valid;
		logic       last;
	} rsp_t;

endpackage

@@ design/pabf_if.sv @@
// Valid/ready channel interfaces for the packet aligned byte FIFO.
// Depends on pabf_pkg for the payload types.
interface pabf_cmd_if import pabf_pkg::*; ();
	logic valid;
	logic ready;
	cmd_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface pabf_rsp_if import pabf_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ design/packet_aligned_byte_fifo.sv @@
// Byte ring buffer with whole-message admission and stream or packet-aligned
// reads. A write request carries one message byte; its status result is loaded
// into the result register at the accepting edge and is offered from the next
// cycle, and writes run at one request per cycle while each result is taken.
// A read request returns up to MAX_READ bytes, one per cycle unless results
// stall, out of a single-port byte store with a registered read; the next
// request is taken once the final byte has left the read data register and,
// in packet mode, the read pointer has stepped over the unread rest of the
// packet, one byte per step (at most PACKET_BYTES). The store needs no
// clearing after reset. Depends on pabf_pkg and pabf_if.
module packet_aligned_byte_fifo import pabf_pkg::*; #(
	parameter int BUFFER_DEPTH = 256,
	parameter int PACKET_BYTES = 16,
	parameter int MAX_READ     = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	pabf_cmd_if.sink    cmd,
	pabf_rsp_if.source  rsp
);

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int UW = AW + 1;
	localparam int LW = ((UW > 10) ? UW : 10) + 1;
	localparam int OW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
	localparam int TW = $clog2(PACKET_BYTES + 1);
	localparam int EW = $clog2(MAX_READ + 1);

	// byte store
	logic [7:0]    mem_q [BUFFER_DEPTH];

	// pointers and message state
	logic [AW-1:0] wr_addr_q, rd_addr_q;
	logic          wr_ph_q, rd_ph_q;
	logic [OW-1:0] pkt_off_q;
	logic [UW-1:0] msg_rem_q;
	status_t       msg_st_q;
	logic          pkt_mode_q;

	// read sequencer
	state_t        state_q, state_d;
	logic [EW-1:0] emit_q;
	logic [TW-1:0] skip_q;
	logic          trunc_q;

	// read data stage and result register
	logic          rd_vld_s1, rd_last_s1;
	logic [7:0]    rdata_s1;
	logic          out_vld_q;
	rsp_t          out_q;

	logic          cmd_rdy, cmd_acc, is_rd, is_wr;
	logic          rd_issue, skip_step, rd_adv, s1_move;
	logic [UW-1:0] used;
	logic          empty;

	// write decision
	status_t       wst;
	logic [UW-1:0] rem0, rem_nxt;
	logic          do_store;

	// read decision
	logic [LW-1:0] size, avail, to_end, residual, n_rd, adv, skip_amt;
	logic          trunc;

	// next pointer values
	logic [AW-1:0] rd_addr_nxt, wr_addr_nxt;
	logic          rd_ph_nxt, wr_ph_nxt;
	logic [OW-1:0] pkt_off_nxt;

	logic          direct_res;
	rsp_t          direct_q;

	assign cmd_acc = cmd.valid & cmd_rdy;
	assign is_rd   = (cmd.payload.op == OP_READ);
	assign is_wr   = (cmd.payload.op == OP_WRITE);
	assign s1_move = rd_vld_s1 & (~out_vld_q | rsp.ready);

	// fill level
	always_comb begin
		if (wr_ph_q == rd_ph_q) begin
			used = UW'(wr_addr_q) - UW'(rd_addr_q);
		end else begin
			used = UW'(wr_addr_q) + UW'(BUFFER_DEPTH) - UW'(rd_addr_q);
		end
		empty = (used == '0);
	end

	// admission of a write byte
	always_comb begin
		wst  = msg_st_q;
		rem0 = msg_rem_q;
		if (cmd.payload.start_req) begin
			if (LW'(cmd.payload.msg_len) > LW'(BUFFER_DEPTH)) begin
				wst  = STS_INVALID;
				rem0 = '0;
			end else if (LW'(used) + LW'(cmd.payload.msg_len) > LW'(BUFFER_DEPTH)) begin
				wst  = STS_FULL;
				rem0 = '0;
			end else begin
				wst  = STS_OK;
				rem0 = UW'(cmd.payload.msg_len);
			end
		end
		do_store = (rem0 != '0);
		rem_nxt  = do_store ? rem0 - UW'(1) : rem0;
	end

	// read length, pointer advance and truncation
	always_comb begin
		size     = (LW'(cmd.payload.req_size) > LW'(MAX_READ)) ? LW'(MAX_READ)
		                                                       : LW'(cmd.payload.req_size);
		avail    = LW'(used);
		to_end   = LW'(PACKET_BYTES) - LW'(pkt_off_q);
		residual = (to_end < avail) ? to_end : avail;
		if (pkt_mode_q) begin
			n_rd  = (residual < size) ? residual : size;
			trunc = (residual < to_end);
			adv   = trunc ? to_end : residual;
		end else begin
			n_rd  = (avail < size) ? avail : size;
			trunc = 1'b0;
			adv   = n_rd;
		end
		skip_amt = adv - n_rd;
	end

	// one-step pointer advance
	always_comb begin
		if (rd_addr_q == AW'(BUFFER_DEPTH - 1)) begin
			rd_addr_nxt = '0;
			rd_ph_nxt   = ~rd_ph_q;
			pkt_off_nxt = '0;
		end else begin
			rd_addr_nxt = rd_addr_q + AW'(1);
			rd_ph_nxt   = rd_ph_q;
			pkt_off_nxt = (pkt_off_q == OW'(PACKET_BYTES - 1)) ? '0 : pkt_off_q + OW'(1);
		end
		if (wr_addr_q == AW'(BUFFER_DEPTH - 1)) begin
			wr_addr_nxt = '0;
			wr_ph_nxt   = ~wr_ph_q;
		end else begin
			wr_addr_nxt = wr_addr_q + AW'(1);
			wr_ph_nxt   = wr_ph_q;
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_acc && is_rd && !empty) begin
					if (n_rd != '0) begin
						state_d = ST_READ;
					end else if (skip_amt != '0) begin
						state_d = ST_SKIP;
					end
				end
			end
			ST_READ: begin
				if (rd_issue && emit_q == EW'(1)) begin
					state_d = (skip_q != '0) ? ST_SKIP : ST_IDLE;
				end
			end
			ST_SKIP: begin
				if (skip_q == TW'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		cmd_rdy   = 1'b0;
		rd_issue  = 1'b0;
		skip_step = 1'b0;
		case (state_q)
			ST_IDLE: cmd_rdy   = ~rd_vld_s1 & (~out_vld_q | rsp.ready);
			ST_READ: rd_issue  = ~rd_vld_s1 | s1_move;
			ST_SKIP: skip_step = 1'b1;
			default: cmd_rdy   = 1'b0;
		endcase
		rd_adv = rd_issue | skip_step;
	end

	// result produced directly by an accepted request
	always_comb begin
		direct_res = 1'b0;
		direct_q   = '{status: STS_OK, rdata: 8'h00, rdata_valid: 1'b0, last: 1'b1};
		if (cmd_acc) begin
			if (is_wr) begin
				direct_res      = 1'b1;
				direct_q.status = wst;
			end else if (empty) begin
				direct_res      = 1'b1;
				direct_q.status = STS_EMPTY;
			end else if (n_rd == '0) begin
				direct_res = 1'b1;
			end
		end
	end

	assign cmd.ready   = cmd_rdy;
	assign rsp.valid   = out_vld_q;
	assign rsp.payload = out_q;

	// byte store: write port for admitted bytes, registered read for the sequencer
	always_ff @(posedge clk) begin
		if (cmd_acc && is_wr && do_store) begin
			mem_q[wr_addr_q] <= cmd.payload.data;
		end
		if (rd_issue) begin
			rdata_s1   <= mem_q[rd_addr_q];
			rd_last_s1 <= (emit_q == EW'(1));
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_q <= '{status: STS_OK, rdata: rdata_s1, rdata_valid: 1'b1,
			           last: rd_last_s1};
		end else if (direct_res) begin
			out_q <= direct_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wr_addr_q  <= '0;
			wr_ph_q    <= 1'b0;
			rd_addr_q  <= '0;
			rd_ph_q    <= 1'b0;
			pkt_off_q  <= '0;
			msg_rem_q  <= '0;
			msg_st_q   <= STS_OK;
			pkt_mode_q <= 1'b0;
			emit_q     <= '0;
			skip_q     <= '0;
			trunc_q    <= 1'b0;
			rd_vld_s1  <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				pkt_mode_q <= cfg_wdata;
			end

			// write request
			if (cmd_acc && is_wr) begin
				msg_st_q  <= wst;
				msg_rem_q <= rem_nxt;
				if (do_store) begin
					wr_addr_q <= wr_addr_nxt;
					wr_ph_q   <= wr_ph_nxt;
				end
			end

			// read request setup
			if (cmd_acc && is_rd && !empty) begin
				emit_q  <= EW'(n_rd);
				skip_q  <= TW'(skip_amt);
				trunc_q <= trunc;
			end
			if (rd_issue) begin
				emit_q <= emit_q - EW'(1);
			end
			if (skip_step) begin
				skip_q <= skip_q - TW'(1);
				// short packet: buffer emptied at the new read pointer
				if (skip_q == TW'(1) && trunc_q) begin
					wr_addr_q <= rd_addr_nxt;
					wr_ph_q   <= rd_ph_nxt;
				end
			end
			if (rd_adv) begin
				rd_addr_q <= rd_addr_nxt;
				rd_ph_q   <= rd_ph_nxt;
				pkt_off_q <= pkt_off_nxt;
			end

			// read data stage
			if (rd_issue) begin
				rd_vld_s1 <= 1'b1;
			end else if (s1_move) begin
				rd_vld_s1 <= 1'b0;
			end

			// result register
			if (s1_move || direct_res) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	// fill level never passes the capacity; a short-packet skip runs the read
	// pointer past the write pointer until its last step
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_SKIP) |-> (LW'(used) <= LW'(BUFFER_DEPTH)))
		else $error("fill level above capacity");

	// a held read byte must not be overwritten by a new store read
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_vld_s1 && !s1_move) |=> ($stable(rdata_s1) && rd_vld_s1))
		else $error("read data stage overwritten while stalled");

	// the byte sequencer never runs with nothing left to read
	a_emit_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (emit_q != '0))
		else $error("read state with zero bytes left");

	// packet offset stays inside a packet
	a_pkt_off: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, pkt_off_q} < (OW + 1)'(PACKET_BYTES))
		else $error("packet offset out of range");
`endif

endmodule
